// ===== hdl/cam_iv_pkg.sv =====
// cam_iv_pkg.sv: shared types and constants of the camera intervalometer sequencer
`timescale 1ns / 1ps

package cam_iv_pkg;

    localparam int unsigned TimeW      = 23;
    localparam int unsigned PhaseW     = 24;
    localparam int unsigned CountW     = 8;
    localparam int unsigned CmdW       = 3;
    localparam int unsigned CfgIndexW  = 3;
    localparam int unsigned InDataW    = 8;
    localparam int unsigned OutDataW   = 8;
    localparam int unsigned BlinkPeriodDefault = 400;

    // command codes; the two unused codes are ignored
    localparam logic [CmdW-1:0] CMD_NONE     = 3'd0;
    localparam logic [CmdW-1:0] CMD_START    = 3'd1;
    localparam logic [CmdW-1:0] CMD_START_ND = 3'd2;
    localparam logic [CmdW-1:0] CMD_HOLD     = 3'd3;
    localparam logic [CmdW-1:0] CMD_STOP     = 3'd4;
    localparam logic [CmdW-1:0] CMD_TOGGLE   = 3'd5;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] REG_START_DELAY = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_SHOT_COUNT  = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_INTERVAL    = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_FOCUS       = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_TRIGGER     = 3'd4;

    typedef struct packed {
        logic [TimeW-1:0]  start_delay_ms;
        logic [CountW-1:0] shot_count;
        logic [TimeW-1:0]  interval_ms;
        logic [TimeW-1:0]  focus_ms;
        logic [TimeW-1:0]  trigger_ms;
    } t_cfg;

    typedef struct packed {
        logic run_active;
        logic led_pin;
        logic waiting_flag;
        logic trigger_pin;
        logic focus_pin;
    } t_result;

endpackage

// ===== hdl/cam_iv_cfg.sv =====
// cam_iv_cfg.sv: configuration register file of the intervalometer
`timescale 1ns / 1ps

module cam_iv_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [cam_iv_pkg::CfgIndexW-1:0]    i_index,
    input  logic [cam_iv_pkg::TimeW-1:0]        i_wdata,
    output cam_iv_pkg::t_cfg                    o_cfg
);

    cam_iv_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delay_ms <= '0;
            r_cfg.shot_count     <= cam_iv_pkg::CountW'(1);
            r_cfg.interval_ms    <= '0;
            r_cfg.focus_ms       <= '0;
            r_cfg.trigger_ms     <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                cam_iv_pkg::REG_START_DELAY: r_cfg.start_delay_ms <= i_wdata;
                cam_iv_pkg::REG_SHOT_COUNT:  r_cfg.shot_count <= i_wdata[cam_iv_pkg::CountW-1:0];
                cam_iv_pkg::REG_INTERVAL:    r_cfg.interval_ms <= i_wdata;
                cam_iv_pkg::REG_FOCUS:       r_cfg.focus_ms <= i_wdata;
                cam_iv_pkg::REG_TRIGGER:     r_cfg.trigger_ms <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/cam_iv_core.sv =====
// cam_iv_core.sv: sequencer state and the per-tick update
`timescale 1ns / 1ps

module cam_iv_core #(
    parameter int unsigned BLINK_PERIOD = cam_iv_pkg::BlinkPeriodDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [cam_iv_pkg::CmdW-1:0]     i_cmd,
    input  logic                            i_hold_trigger,
    input  logic                            i_hold_focus,
    input  cam_iv_pkg::t_cfg                i_cfg,
    output cam_iv_pkg::t_result             o_res
);

    localparam int unsigned BW = (BLINK_PERIOD > 2) ? $clog2(BLINK_PERIOD) : 1;
    localparam logic [BW-1:0] BlinkHalf   = BW'(BLINK_PERIOD / 2);
    localparam logic [BW:0]   BlinkPeriod = (BW + 1)'(BLINK_PERIOD);

    localparam int unsigned TW = cam_iv_pkg::TimeW;
    localparam int unsigned PW = cam_iv_pkg::PhaseW;
    localparam int unsigned CW = cam_iv_pkg::CountW;

    logic          r_active, n_active;
    logic          r_in_delay, n_in_delay;
    logic [TW-1:0] r_delay_count, n_delay_count;
    logic [PW-1:0] r_phase_count, n_phase_count;
    logic [CW-1:0] r_shot_index, n_shot_index;
    logic          r_remote_hold, n_remote_hold;
    logic [BW-1:0] r_blink_count, n_blink_count;
    logic          r_blink_started, n_blink_started;

    always_comb begin
        logic          v_trig;
        logic          v_foc;
        logic          v_wait;
        logic          v_led;
        logic          v_shot_phase;
        logic [PW-1:0] v_ft;
        logic [PW-1:0] v_ivl;
        logic [CW-1:0] v_last;
        logic [BW:0]   v_blink_inc;

        n_active        = r_active;
        n_in_delay      = r_in_delay;
        n_delay_count   = r_delay_count;
        n_phase_count   = r_phase_count;
        n_shot_index    = r_shot_index;
        n_remote_hold   = r_remote_hold;
        n_blink_count   = r_blink_count;
        n_blink_started = r_blink_started;
        v_trig          = i_hold_trigger;
        v_foc           = i_hold_focus;
        v_wait          = 1'b0;
        v_shot_phase    = 1'b0;
        v_blink_inc     = '0;

        unique case (i_cmd)
            cam_iv_pkg::CMD_START, cam_iv_pkg::CMD_START_ND, cam_iv_pkg::CMD_HOLD: begin
                n_active      = 1'b1;
                n_in_delay    = (i_cmd != cam_iv_pkg::CMD_START_ND);
                n_delay_count = '0;
                n_phase_count = '0;
                n_shot_index  = '0;
                if (i_cmd == cam_iv_pkg::CMD_HOLD) begin
                    n_remote_hold = 1'b1;
                end
            end
            cam_iv_pkg::CMD_STOP: begin
                n_active      = 1'b0;
                n_remote_hold = 1'b0;
            end
            cam_iv_pkg::CMD_TOGGLE: begin
                if (r_active) begin
                    n_active = 1'b0;
                end else begin
                    n_active      = 1'b1;
                    n_in_delay    = 1'b1;
                    n_delay_count = '0;
                    n_phase_count = '0;
                    n_shot_index  = '0;
                end
                n_remote_hold = 1'b0;
            end
            default: ;
        endcase

        v_trig = v_trig | n_remote_hold;

        // effective interval and last shot index
        v_ft   = {1'b0, i_cfg.focus_ms} + {1'b0, i_cfg.trigger_ms};
        v_ivl  = ({1'b0, i_cfg.interval_ms} > v_ft) ? {1'b0, i_cfg.interval_ms} : v_ft;
        v_last = (i_cfg.shot_count != '0) ? i_cfg.shot_count - CW'(1) : '0;

        if (n_active) begin
            v_shot_phase = 1'b1;
            if (n_in_delay) begin
                if (n_delay_count < i_cfg.start_delay_ms) begin
                    v_wait        = 1'b1;
                    n_delay_count = n_delay_count + TW'(1);
                    v_shot_phase  = 1'b0;
                end else begin
                    n_in_delay = 1'b0;
                end
            end
            if (v_shot_phase) begin
                if ((n_shot_index > v_last) ||
                    ((n_shot_index == v_last) && (n_phase_count >= v_ft))) begin
                    n_active = 1'b0;
                end else begin
                    if (n_phase_count < {1'b0, i_cfg.focus_ms}) begin
                        v_foc = 1'b1;
                    end else if (n_phase_count < v_ft) begin
                        v_trig = 1'b1;
                    end else begin
                        v_wait = 1'b1;
                    end
                    n_phase_count = n_phase_count + PW'(1);
                    if (n_phase_count >= v_ivl) begin
                        n_phase_count = '0;
                        n_shot_index  = n_shot_index + CW'(1);
                    end
                end
            end
        end

        // blink phase starts on the first waiting tick and then free-runs
        if (v_wait && !n_blink_started) begin
            n_blink_started = 1'b1;
            n_blink_count   = '0;
        end

        v_led = v_wait ? (n_blink_count >= BlinkHalf) : !v_trig;

        if (n_blink_started) begin
            v_blink_inc   = {1'b0, n_blink_count} + (BW + 1)'(1);
            n_blink_count = (v_blink_inc >= BlinkPeriod) ? '0 : v_blink_inc[BW-1:0];
        end

        o_res.focus_pin    = v_foc | v_trig;
        o_res.trigger_pin  = v_trig;
        o_res.waiting_flag = v_wait;
        o_res.led_pin      = v_led;
        o_res.run_active   = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active        <= 1'b0;
            r_in_delay      <= 1'b0;
            r_delay_count   <= '0;
            r_phase_count   <= '0;
            r_shot_index    <= '0;
            r_remote_hold   <= 1'b0;
            r_blink_count   <= '0;
            r_blink_started <= 1'b0;
        end else if (i_en) begin
            r_active        <= n_active;
            r_in_delay      <= n_in_delay;
            r_delay_count   <= n_delay_count;
            r_phase_count   <= n_phase_count;
            r_shot_index    <= n_shot_index;
            r_remote_hold   <= n_remote_hold;
            r_blink_count   <= n_blink_count;
            r_blink_started <= n_blink_started;
        end
    end

    a_blink_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_started |=> r_blink_started)
        else $error("blink phase lost its start");

    a_blink_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_blink_count} < BlinkPeriod)
        else $error("blink counter out of range");

    a_stop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_cmd == cam_iv_pkg::CMD_STOP) |=> !r_active && !r_remote_hold)
        else $error("stop did not end the run");

endmodule

// ===== hdl/camera_intervalometer_sequencer.sv =====
// camera_intervalometer_sequencer.sv: top level with input and result registers
// a tick transfer lands in the input register; its result moves into the result
// register once that is free or drains, and is shown on the master side from there
// throughput: one tick per clock while results drain; the state updates once per tick
// reset: synchronous active-low clears run state, blink phase, both pipeline
// registers and the configuration (shot count returns to one)
`timescale 1ns / 1ps

module camera_intervalometer_sequencer #(
    parameter int unsigned BLINK_PERIOD = cam_iv_pkg::BlinkPeriodDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] cmd, [3] hold_trigger, [4] hold_focus, [7:5] zero
    input  logic [cam_iv_pkg::InDataW-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] focus_pin, [1] trigger_pin, [2] waiting_flag, [3] led_pin,
    // [4] run_active, [7:5] zero
    output logic [cam_iv_pkg::OutDataW-1:0]     m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [cam_iv_pkg::CfgIndexW-1:0]    i_cfg_index,
    input  logic [cam_iv_pkg::TimeW-1:0]        i_cfg_wdata
);

    logic                           r_in_valid;
    logic [cam_iv_pkg::CmdW-1:0]    r_cmd;
    logic                           r_hold_trigger;
    logic                           r_hold_focus;
    logic                           r_out_valid;
    cam_iv_pkg::t_result            r_res;

    cam_iv_pkg::t_cfg               w_cfg;
    cam_iv_pkg::t_result            w_res;
    logic                           w_adv;

    // the input register moves on whenever the result register is free or drains
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd          <= s_axis_tdata[2:0];
            r_hold_trigger <= s_axis_tdata[3];
            r_hold_focus   <= s_axis_tdata[4];
        end
    end

    cam_iv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    cam_iv_core #(
        .BLINK_PERIOD (BLINK_PERIOD)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_cmd          (r_cmd),
        .i_hold_trigger (r_hold_trigger),
        .i_hold_focus   (r_hold_focus),
        .i_cfg          (w_cfg),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res.run_active, r_res.led_pin, r_res.waiting_flag,
                            r_res.trigger_pin, r_res.focus_pin};

    a_wait_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.waiting_flag |-> r_res.run_active)
        else $error("waiting reported outside a run");

    a_trigger_focus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.trigger_pin |-> r_res.focus_pin)
        else $error("trigger without focus line");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_cmd))
        else $error("pending tick dropped from the input register");

endmodule

// ===== tb/sv/camera_intervalometer_sequencer_tb.sv =====
// camera_intervalometer_sequencer_tb.sv: self-checking testbench of the intervalometer sequencer
`timescale 1ns / 1ps

module camera_intervalometer_sequencer_tb;

    localparam int StallLimit    = 5000;
    localparam int DrainPad      = 4;
    localparam int HoldOffCycles = 300;
    localparam int BlinkPeriod   = cam_iv_pkg::BlinkPeriodDefault;

    localparam logic [cam_iv_pkg::TimeW-1:0] TimeMax     = '1;
    localparam logic [cam_iv_pkg::CmdW-1:0]  CMD_SPARE_6 = 3'd6;
    localparam logic [cam_iv_pkg::CmdW-1:0]  CMD_SPARE_7 = 3'd7;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // [2:0] cmd, [3] hold_trigger, [4] hold_focus, [7:5] zero
    logic [cam_iv_pkg::InDataW-1:0]     s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // [0] focus_pin, [1] trigger_pin, [2] waiting_flag, [3] led_pin, [4] run_active
    logic [cam_iv_pkg::OutDataW-1:0]    m_axis_tdata;
    logic                               i_cfg_wr_en   = 1'b0;
    logic [cam_iv_pkg::CfgIndexW-1:0]   i_cfg_index   = '0;
    logic [cam_iv_pkg::TimeW-1:0]       i_cfg_wdata   = '0;

    camera_intervalometer_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sequencer model state and its copy of the registers
    cam_iv_pkg::t_cfg  cfg_m = '{start_delay_ms: '0, shot_count: 8'd1, interval_ms: '0,
                                 focus_ms: '0, trigger_ms: '0};
    logic                           run_on     = 1'b0;
    logic                           delay_on   = 1'b0;
    logic                           remote_on  = 1'b0;
    logic                           blink_on   = 1'b0;
    logic [cam_iv_pkg::TimeW-1:0]   delay_cnt  = '0;
    logic [cam_iv_pkg::PhaseW-1:0]  phase_cnt  = '0;
    logic [cam_iv_pkg::CountW-1:0]  shots_done = '0;
    int unsigned                    blink_cnt  = 0;

    cam_iv_pkg::t_result pins_q[$];
    cam_iv_pkg::t_result want_pins;
    cam_iv_pkg::t_result got_pins;

    int pin_errors   = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int snd_idle_pct = 18;
    int rcv_idle_pct = 81;
    int hold_left    = 0;
    int stall_cycles = 0;
    bit hold_req     = 1'b0;

    function automatic void start_run(input logic with_delay);
        run_on     = 1'b1;
        delay_on   = with_delay;
        delay_cnt  = '0;
        phase_cnt  = '0;
        shots_done = '0;
    endfunction

    function automatic cam_iv_pkg::t_result predict_pins(
        input logic [cam_iv_pkg::CmdW-1:0] cmd, input logic hold_trig, input logic hold_foc);
        cam_iv_pkg::t_result            r;
        logic                           trig;
        logic                           foc;
        logic                           waiting;
        logic                           led;
        logic                           shot_phase;
        logic [cam_iv_pkg::PhaseW:0]    ft;
        logic [cam_iv_pkg::PhaseW:0]    span;
        logic [cam_iv_pkg::CountW-1:0]  last_shot;
        trig    = hold_trig;
        foc     = hold_foc;
        waiting = 1'b0;
        case (cmd)
            cam_iv_pkg::CMD_START:    start_run(1'b1);
            cam_iv_pkg::CMD_START_ND: start_run(1'b0);
            cam_iv_pkg::CMD_HOLD: begin
                start_run(1'b1);
                remote_on = 1'b1;
            end
            cam_iv_pkg::CMD_STOP: begin
                run_on    = 1'b0;
                remote_on = 1'b0;
            end
            cam_iv_pkg::CMD_TOGGLE: begin
                if (run_on) run_on = 1'b0;
                else start_run(1'b1);
                remote_on = 1'b0;
            end
            default: ;
        endcase
        if (remote_on) trig = 1'b1;
        if (run_on) begin
            shot_phase = 1'b1;
            if (delay_on) begin
                if (delay_cnt < cfg_m.start_delay_ms) begin
                    waiting    = 1'b1;
                    delay_cnt  = delay_cnt + 1'b1;
                    shot_phase = 1'b0;
                end else begin
                    delay_on = 1'b0;
                end
            end
            if (shot_phase) begin
                ft        = cfg_m.focus_ms + cfg_m.trigger_ms;
                span      = (cfg_m.interval_ms > ft) ? cfg_m.interval_ms : ft;
                last_shot = (cfg_m.shot_count > 0) ? cfg_m.shot_count - 1'b1 : '0;
                if (shots_done > last_shot || (shots_done == last_shot && phase_cnt >= ft)) begin
                    run_on = 1'b0;
                end else begin
                    if (phase_cnt < cfg_m.focus_ms) foc = 1'b1;
                    else if (phase_cnt < ft) trig = 1'b1;
                    else waiting = 1'b1;
                    phase_cnt = phase_cnt + 1'b1;
                    // interval done (or already overrun after a shortened interval)
                    if (phase_cnt >= span) begin
                        phase_cnt  = '0;
                        shots_done = shots_done + 1'b1;
                    end
                end
            end
        end
        if (waiting && !blink_on) begin
            blink_on  = 1'b1;
            blink_cnt = 0;
        end
        led = waiting ? (blink_cnt >= BlinkPeriod / 2) : !trig;
        // blink phase runs on every tick once started, waiting or not
        if (blink_on) begin
            blink_cnt++;
            if (blink_cnt >= BlinkPeriod) blink_cnt = 0;
        end
        r.focus_pin    = foc | trig;
        r.trigger_pin  = trig;
        r.waiting_flag = waiting;
        r.led_pin      = led;
        r.run_active   = run_on;
        return r;
    endfunction

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [cam_iv_pkg::TimeW-1:0] rand_time();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return cam_iv_pkg::TimeW'($urandom_range(0, 8));
        if (sel < 85) return cam_iv_pkg::TimeW'($urandom_range(9, 40));
        // long enough for the led to pass through both blink halves
        if (sel < 95) return cam_iv_pkg::TimeW'($urandom_range(150, 450));
        return cam_iv_pkg::TimeW'($urandom_range(0, 32'h7F_FFFF));
    endfunction

    function automatic logic [cam_iv_pkg::CmdW-1:0] rand_start_cmd();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return cam_iv_pkg::CMD_START;
        if (sel < 70) return cam_iv_pkg::CMD_START_ND;
        if (sel < 85) return cam_iv_pkg::CMD_TOGGLE;
        return cam_iv_pkg::CMD_HOLD;
    endfunction

    function automatic logic [cam_iv_pkg::CmdW-1:0] rand_any_cmd(input int pct);
        if (chance(pct)) return cam_iv_pkg::CmdW'($urandom_range(0, 7));
        return cam_iv_pkg::CMD_NONE;
    endfunction

    function automatic void note_failure(input string what);
        if (pin_errors < 10) $display("%s", what);
        pin_errors++;
    endfunction

    task automatic send_tick(input logic [cam_iv_pkg::CmdW-1:0] cmd, input logic hold_trig,
                             input logic hold_foc);
        while (chance(snd_idle_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, hold_foc, hold_trig, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        pins_q.push_back(predict_pins(cmd, hold_trig, hold_foc));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pins_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [cam_iv_pkg::CfgIndexW-1:0] idx,
                             input logic [cam_iv_pkg::TimeW-1:0] value);
        wait_drained();
        repeat (DrainPad) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            cam_iv_pkg::REG_START_DELAY: cfg_m.start_delay_ms = value;
            cam_iv_pkg::REG_SHOT_COUNT:  cfg_m.shot_count     = value[cam_iv_pkg::CountW-1:0];
            cam_iv_pkg::REG_INTERVAL:    cfg_m.interval_ms    = value;
            cam_iv_pkg::REG_FOCUS:       cfg_m.focus_ms       = value;
            cam_iv_pkg::REG_TRIGGER:     cfg_m.trigger_ms     = value;
            default: ;
        endcase
    endtask

    task automatic test_zero_times();
        // all times zero: the run ends at once without a shot
        send_tick(cam_iv_pkg::CMD_START, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_NONE, 1'b1, 1'b0);
        send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b1);
    endtask

    task automatic test_delay_and_count();
        cfg_write(cam_iv_pkg::REG_START_DELAY, 23'd2);
        cfg_write(cam_iv_pkg::REG_SHOT_COUNT, 23'd0);
        cfg_write(cam_iv_pkg::REG_INTERVAL, 23'd0);
        cfg_write(cam_iv_pkg::REG_FOCUS, 23'd1);
        cfg_write(cam_iv_pkg::REG_TRIGGER, 23'd1);
        send_tick(cam_iv_pkg::CMD_START_ND, 1'b0, 1'b0);
        repeat (3) send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_START, 1'b0, 1'b0);
        repeat (3) send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b0);
    endtask

    task automatic test_commands();
        send_tick(cam_iv_pkg::CMD_TOGGLE, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_TOGGLE, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_HOLD, 1'b0, 1'b0);
        // restart while running keeps the remote hold
        send_tick(cam_iv_pkg::CMD_START, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_NONE, 1'b1, 1'b1);
        send_tick(cam_iv_pkg::CMD_STOP, 1'b0, 1'b0);
        send_tick(CMD_SPARE_6, 1'b1, 1'b0);
        send_tick(CMD_SPARE_7, 1'b0, 1'b1);
    endtask

    task automatic test_midrun_change();
        cfg_write(cam_iv_pkg::REG_INTERVAL, 23'd6);
        cfg_write(cam_iv_pkg::REG_SHOT_COUNT, 23'd3);
        send_tick(cam_iv_pkg::CMD_START_ND, 1'b0, 1'b0);
        repeat (3) send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b0);
        // phase now past the shortened interval
        cfg_write(cam_iv_pkg::REG_INTERVAL, 23'd1);
        repeat (2) send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b0);
        cfg_write(cam_iv_pkg::REG_SHOT_COUNT, 23'd1);
        repeat (2) send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b0);
    endtask

    task automatic test_extremes();
        cfg_write(cam_iv_pkg::REG_START_DELAY, TimeMax);
        cfg_write(cam_iv_pkg::REG_SHOT_COUNT, 23'd255);
        cfg_write(cam_iv_pkg::REG_INTERVAL, TimeMax);
        cfg_write(cam_iv_pkg::REG_FOCUS, TimeMax);
        cfg_write(cam_iv_pkg::REG_TRIGGER, TimeMax);
        send_tick(cam_iv_pkg::CMD_START, 1'b1, 1'b1);
        send_tick(cam_iv_pkg::CMD_NONE, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_START_ND, 1'b0, 1'b0);
        send_tick(cam_iv_pkg::CMD_NONE, 1'b1, 1'b0);
    endtask

    task automatic run_segment(input int max_len);
        int                                 len;
        int                                 n;
        logic [cam_iv_pkg::CfgIndexW-1:0]   idx;
        logic [cam_iv_pkg::CmdW-1:0]        cmd;
        if (chance(35)) begin
            n = $urandom_range(1, 5);
            repeat (n) begin
                idx = cam_iv_pkg::CfgIndexW'($urandom_range(cam_iv_pkg::REG_START_DELAY,
                                                            cam_iv_pkg::REG_TRIGGER));
                if (idx == cam_iv_pkg::REG_SHOT_COUNT)
                    cfg_write(idx, chance(85) ? cam_iv_pkg::TimeW'($urandom_range(1, 6))
                                              : cam_iv_pkg::TimeW'($urandom_range(0, 255)));
                else
                    cfg_write(idx, rand_time());
            end
        end
        // without a start the current run goes on under the new registers
        if (chance(75)) send_tick(rand_start_cmd(), chance(12), chance(12));
        len = chance(15) ? $urandom_range(220, 450) : $urandom_range(5, 60);
        if (len > max_len) len = max_len;
        repeat (len) begin
            cmd = rand_any_cmd(6);
            send_tick(cmd, chance(12), chance(12));
        end
    endtask

    task automatic test_random(input int snd_pct, input int rcv_pct, input int count);
        int target;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        target = ticks_sent + count;
        while (ticks_sent < target) run_segment(target - ticks_sent);
    endtask

    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (60) send_tick(rand_any_cmd(10), chance(12), chance(12));
        wait_drained();
    endtask

    // receiver side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HoldOffCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !chance(rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got_pins = m_axis_tdata[4:0];
            if (pins_q.size() == 0) begin
                note_failure($sformatf("result %0d with nothing expected: tdata=%b",
                                       results_seen, m_axis_tdata));
            end else begin
                want_pins = pins_q.pop_front();
                if (got_pins != want_pins || m_axis_tdata[7:5] != 3'b000)
                    note_failure($sformatf({"result %0d mismatch: expected run=%b led=%b ",
                                            "wait=%b trig=%b focus=%b, got tdata=%b"},
                                           results_seen, want_pins.run_active,
                                           want_pins.led_pin, want_pins.waiting_flag,
                                           want_pins.trigger_pin, want_pins.focus_pin,
                                           m_axis_tdata));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_times();
        test_delay_and_count();
        test_commands();
        test_midrun_change();
        test_extremes();
        test_random(18, 81, 520);
        test_random(81, 18, 520);
        test_backpressure();
        test_random(0, 0, 520);
        wait_drained();
        repeat (DrainPad * 2) @(posedge i_clk);
        if (pin_errors == 0 && pins_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
